// ----- rtl/core/csrs_pkg.sv -----
`timescale 1ns / 1ps
package csrs_pkg;
  localparam int unsigned WRITE_QUEUE_DEPTH_DEF = 8;
  localparam int unsigned READ_QUEUE_DEPTH_DEF = 8;
  localparam int unsigned POLL_TABLE_SIZE_DEF = 8;

  localparam logic [1:0] MODE_WRITE = 2'd0;
  localparam logic [1:0] MODE_READ = 2'd1;
  localparam logic [1:0] MODE_SLOT = 2'd2;

  localparam logic [1:0] ACT_NONE = 2'd0;
  localparam logic [1:0] ACT_DOWNLOAD = 2'd1;
  localparam logic [1:0] ACT_UPLOAD = 2'd2;
  localparam logic [1:0] ACT_POLL = 2'd3;

  localparam logic CFG_REMOTE_NODE = 1'b0;
  localparam logic CFG_POLL_PERIOD = 1'b1;

  localparam logic [2:0] SIZE_1 = 3'd1;
  localparam logic [2:0] SIZE_2 = 3'd2;
  localparam logic [2:0] SIZE_4 = 3'd4;

  typedef struct packed {
    logic [1:0]  mode;
    logic [6:0]  node;
    logic [15:0] index;
    logic [7:0]  subindex;
    logic [2:0]  size;
    logic [31:0] value;
    logic [31:0] now;
    logic        idle;
  } item_t;

  function automatic logic [15:0] poll_index(input logic [2:0] t);
    logic [15:0] r;
    case (t)
      3'd0: r = 16'h1000;
      3'd1: r = 16'h1001;
      3'd6: r = 16'h6041;
      3'd7: r = 16'h6061;
      default: r = 16'h1018;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] poll_sub(input logic [2:0] t);
    logic [7:0] r;
    case (t)
      3'd2: r = 8'd1;
      3'd3: r = 8'd2;
      3'd4: r = 8'd3;
      3'd5: r = 8'd4;
      default: r = 8'd0;
    endcase
    return r;
  endfunction
endpackage

// ----- rtl/core/coalescing_sdo_request_scheduler_core.sv -----
`timescale 1ns / 1ps
// Channel  | Handshake          | Payload
// request  | start / busy       | mode node_id obj_index obj_subindex size value now_ms engine_idle
// result   | done (1 cycle)     | accepted action out_* write_fill read_fill drop_total
// config   | cfg_we / cfg_index | cfg_data
// The front part pushes each transaction into a two-entry queue while the queue
// is not full; the back part handles one queued transaction at a time in two
// steps (key match, then update). Reset is synchronous; queues and counters
// empty, registers at 1 and 100. busy is high while the queue is full.
// The receiver cannot stall; done lasts exactly one cycle.
module coalescing_sdo_request_scheduler_core #(
  parameter int unsigned WRITE_QUEUE_DEPTH = csrs_pkg::WRITE_QUEUE_DEPTH_DEF,
  parameter int unsigned READ_QUEUE_DEPTH = csrs_pkg::READ_QUEUE_DEPTH_DEF,
  parameter int unsigned POLL_TABLE_SIZE = csrs_pkg::POLL_TABLE_SIZE_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  logic [1:0] mode,
  input  logic [6:0] node_id,
  input  logic [15:0] obj_index,
  input  logic [7:0] obj_subindex,
  input  logic [2:0] size,
  input  logic [31:0] value,
  input  logic [31:0] now_ms,
  input  logic engine_idle,
  input  logic cfg_we,
  input  logic cfg_index,
  input  logic [15:0] cfg_data,
  output logic done,
  output logic accepted,
  output logic [1:0] action,
  output logic [6:0] out_node,
  output logic [15:0] out_index,
  output logic [7:0] out_subindex,
  output logic [2:0] out_size,
  output logic [31:0] out_value,
  output logic [3:0] write_fill,
  output logic [3:0] read_fill,
  output logic [15:0] drop_total
);
  import csrs_pkg::*;
  logic [6:0] remote_node;
  logic [15:0] poll_period;
  logic q_push, q_full, q_valid, q_pop;
  item_t q_in, q_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      remote_node <= 7'd1;
      poll_period <= 16'd100;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_REMOTE_NODE: remote_node <= cfg_data[6:0];
        CFG_POLL_PERIOD: poll_period <= cfg_data;
        default: ;
      endcase
    end
  end

  assign busy = q_full;

  csrs_front u_front (
    .clk, .rst, .start, .mode, .node_id, .obj_index, .obj_subindex, .size,
    .value, .now_ms, .engine_idle, .q_full, .q_push, .q_item(q_in)
  );

  csrs_queue u_queue (
    .clk, .rst, .push(q_push), .din(q_in), .full(q_full), .valid(q_valid),
    .pop(q_pop), .dout(q_out)
  );

  csrs_back #(
    .WQD(WRITE_QUEUE_DEPTH), .RQD(READ_QUEUE_DEPTH), .PTS(POLL_TABLE_SIZE)
  ) u_back (
    .clk, .rst, .q_valid, .q_item(q_out), .q_pop, .remote_node,
    .poll_period_ms(poll_period), .done, .accepted, .action, .out_node,
    .out_index, .out_subindex, .out_size, .out_value, .write_fill,
    .read_fill, .drop_total
  );
endmodule

// ----- rtl/core/csrs_front.sv -----
`timescale 1ns / 1ps
module csrs_front (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic [1:0] mode,
  input  logic [6:0] node_id,
  input  logic [15:0] obj_index,
  input  logic [7:0] obj_subindex,
  input  logic [2:0] size,
  input  logic [31:0] value,
  input  logic [31:0] now_ms,
  input  logic engine_idle,
  input  logic q_full,
  output logic q_push,
  output csrs_pkg::item_t q_item
);
  import csrs_pkg::*;
  always_comb begin
    q_push = start && !q_full;
    q_item.mode = mode;
    q_item.node = node_id;
    q_item.index = obj_index;
    q_item.subindex = obj_subindex;
    q_item.size = size;
    q_item.value = value;
    q_item.now = now_ms;
    q_item.idle = engine_idle;
  end
  logic unused;
  assign unused = clk ^ rst;
endmodule

// ----- rtl/core/csrs_back.sv -----
`timescale 1ns / 1ps
module csrs_back #(
  parameter int unsigned WQD = csrs_pkg::WRITE_QUEUE_DEPTH_DEF,
  parameter int unsigned RQD = csrs_pkg::READ_QUEUE_DEPTH_DEF,
  parameter int unsigned PTS = csrs_pkg::POLL_TABLE_SIZE_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic q_valid,
  input  csrs_pkg::item_t q_item,
  output logic q_pop,
  input  logic [6:0] remote_node,
  input  logic [15:0] poll_period_ms,
  output logic done,
  output logic accepted,
  output logic [1:0] action,
  output logic [6:0] out_node,
  output logic [15:0] out_index,
  output logic [7:0] out_subindex,
  output logic [2:0] out_size,
  output logic [31:0] out_value,
  output logic [3:0] write_fill,
  output logic [3:0] read_fill,
  output logic [15:0] drop_total
);
  import csrs_pkg::*;
  localparam int WW = (WQD > 1) ? $clog2(WQD) : 1;
  localparam int RW = (RQD > 1) ? $clog2(RQD) : 1;
  localparam int PW = (PTS > 1) ? $clog2(PTS) : 1;
  localparam int WCW = $clog2(WQD + 1);
  localparam int RCW = $clog2(RQD + 1);

  typedef enum logic {ST_LOOK, ST_ACT} state_t;
  state_t state;

  logic [30:0] wkey [WQD];
  logic [34:0] wpay [WQD];
  logic [30:0] rkey [RQD];
  logic [WW-1:0] whead, wtail;
  logic [RW-1:0] rhead, rtail;
  logic [WCW-1:0] wcount;
  logic [RCW-1:0] rcount;
  logic [31:0] next_poll;
  logic [PW-1:0] pptr;
  logic [15:0] dropped;
  logic whit, rhit;
  logic [WW-1:0] wslot;
  logic [30:0] key;
  item_t it;
  logic [2:0] tix;

  assign it = q_item;
  assign key = {it.node, it.index, it.subindex};
  assign q_pop = (state == ST_ACT);

  always_ff @(posedge clk) begin
    whit <= 1'b0;
    rhit <= 1'b0;
    wslot <= '0;
    for (int i = 0; i < WQD; i++) begin
      if (wkey[i] == key && (wcount == WCW'(WQD) ||
          ((whead >= wtail) ? (WW'(i) >= wtail && WW'(i) < whead)
                            : (WW'(i) >= wtail || WW'(i) < whead)))) begin
        whit <= 1'b1;
        wslot <= WW'(i);
      end
    end
    for (int i = 0; i < RQD; i++) begin
      if (rkey[i] == key && (rcount == RCW'(RQD) ||
          ((rhead >= rtail) ? (RW'(i) >= rtail && RW'(i) < rhead)
                            : (RW'(i) >= rtail || RW'(i) < rhead)))) begin
        rhit <= 1'b1;
      end
    end
  end

  assign tix = 3'(pptr);
  assign write_fill = 4'(wcount);
  assign read_fill = 4'(rcount);
  assign drop_total = dropped;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOOK;
      whead <= '0; wtail <= '0; wcount <= '0;
      rhead <= '0; rtail <= '0; rcount <= '0;
      next_poll <= '0; pptr <= '0; dropped <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_LOOK: begin
          if (q_valid) state <= ST_ACT;
        end
        ST_ACT: begin
          state <= ST_LOOK;
          done <= 1'b1;
          accepted <= 1'b0;
          action <= ACT_NONE;
          out_node <= '0; out_index <= '0; out_subindex <= '0;
          out_size <= '0; out_value <= '0;
          unique case (it.mode)
            MODE_WRITE: begin
              if (it.node != '0 && it.index != '0 &&
                  (it.size == SIZE_1 || it.size == SIZE_2 || it.size == SIZE_4)) begin
                if (whit) begin
                  wpay[wslot] <= {it.size, it.value};
                  accepted <= 1'b1;
                end else if (wcount == WCW'(WQD)) begin
                  dropped <= dropped + 16'd1;
                end else begin
                  wkey[whead] <= key;
                  wpay[whead] <= {it.size, it.value};
                  whead <= (whead == WW'(WQD - 1)) ? '0 : whead + 1'b1;
                  wcount <= wcount + 1'b1;
                  accepted <= 1'b1;
                end
              end
            end
            MODE_READ: begin
              if (it.node != '0 && it.index != '0) begin
                if (rhit) begin
                  accepted <= 1'b1;
                end else if (rcount == RCW'(RQD)) begin
                  dropped <= dropped + 16'd1;
                end else begin
                  rkey[rhead] <= key;
                  rhead <= (rhead == RW'(RQD - 1)) ? '0 : rhead + 1'b1;
                  rcount <= rcount + 1'b1;
                  accepted <= 1'b1;
                end
              end
            end
            MODE_SLOT: begin
              if (it.idle) begin
                if (wcount != '0) begin
                  wtail <= (wtail == WW'(WQD - 1)) ? '0 : wtail + 1'b1;
                  wcount <= wcount - 1'b1;
                  action <= ACT_DOWNLOAD;
                  {out_node, out_index, out_subindex} <= wkey[wtail];
                  {out_size, out_value} <= wpay[wtail];
                end else if (rcount != '0) begin
                  rtail <= (rtail == RW'(RQD - 1)) ? '0 : rtail + 1'b1;
                  rcount <= rcount - 1'b1;
                  action <= ACT_UPLOAD;
                  {out_node, out_index, out_subindex} <= rkey[rtail];
                end else if (it.now >= next_poll) begin
                  next_poll <= it.now + {16'd0, poll_period_ms};
                  action <= ACT_POLL;
                  out_node <= remote_node;
                  out_index <= poll_index(tix);
                  out_subindex <= poll_sub(tix);
                  pptr <= (pptr == PW'(PTS - 1)) ? '0 : pptr + 1'b1;
                end
              end
            end
            default: ;
          endcase
        end
        default: state <= ST_LOOK;
      endcase
    end
  end
endmodule

// ----- rtl/core/csrs_queue.sv -----
`timescale 1ns / 1ps
module csrs_queue (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  csrs_pkg::item_t din,
  output logic full,
  output logic valid,
  input  logic pop,
  output csrs_pkg::item_t dout
);
  import csrs_pkg::*;
  item_t mem [2];
  logic wp, rp;
  logic [1:0] cnt;
  assign full = (cnt == 2'd2);
  assign valid = (cnt != 2'd0);
  assign dout = mem[rp];
  always_ff @(posedge clk) begin
    if (push) mem[wp] <= din;
    if (rst) begin
      wp <= 1'b0; rp <= 1'b0; cnt <= '0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule
